// File: rtl/ctbe_pkg.sv
// Package for the content type by extension unit.
// Holds character codes, content-type codes and the constant extension table.
// No dependencies.
package ctbe_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_EXT_CHARS_DEF = 7;
  localparam int TABLE_ENTRIES_DEF = 105;

  // Extension table geometry: entries defined, bytes compared per entry
  localparam int EXT_STORED = 103;
  localparam int EXT_CMP    = 6;
  localparam int EXT_WORD_W = 8 * EXT_CMP;
  localparam int CT_W       = 6;

  // Bytes with a meaning of their own in a name
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_QMARK  = 8'h3F;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Content-type codes
  localparam logic [CT_W-1:0] CT_UNKNOWN         = 6'd0;
  localparam logic [CT_W-1:0] CT_TEXT_H323       = 6'd1;
  localparam logic [CT_W-1:0] CT_APP_POSTSCRIPT  = 6'd2;
  localparam logic [CT_W-1:0] CT_AUDIO_AIFF      = 6'd3;
  localparam logic [CT_W-1:0] CT_VIDEO_ASF       = 6'd4;
  localparam logic [CT_W-1:0] CT_TEXT_HTML       = 6'd5;
  localparam logic [CT_W-1:0] CT_AUDIO_BASIC     = 6'd6;
  localparam logic [CT_W-1:0] CT_VIDEO_MSVIDEO   = 6'd7;
  localparam logic [CT_W-1:0] CT_TEXT_PLAIN      = 6'd8;
  localparam logic [CT_W-1:0] CT_APP_OCTET       = 6'd9;
  localparam logic [CT_W-1:0] CT_IMAGE_BMP       = 6'd10;
  localparam logic [CT_W-1:0] CT_IMAGE_CIS_COD   = 6'd11;
  localparam logic [CT_W-1:0] CT_TEXT_CSS        = 6'd12;
  localparam logic [CT_W-1:0] CT_TEXT_SETEXT     = 6'd13;
  localparam logic [CT_W-1:0] CT_WORLD_VRML      = 6'd14;
  localparam logic [CT_W-1:0] CT_IMAGE_GIF       = 6'd15;
  localparam logic [CT_W-1:0] CT_APP_GTAR        = 6'd16;
  localparam logic [CT_W-1:0] CT_APP_GZIP        = 6'd17;
  localparam logic [CT_W-1:0] CT_TEXT_COMPONENT  = 6'd18;
  localparam logic [CT_W-1:0] CT_TEXT_WEBVIEW    = 6'd19;
  localparam logic [CT_W-1:0] CT_IMAGE_ICON      = 6'd20;
  localparam logic [CT_W-1:0] CT_IMAGE_IEF       = 6'd21;
  localparam logic [CT_W-1:0] CT_IMAGE_PIPEG     = 6'd22;
  localparam logic [CT_W-1:0] CT_IMAGE_JPEG      = 6'd23;
  localparam logic [CT_W-1:0] CT_APP_JAVASCRIPT  = 6'd24;
  localparam logic [CT_W-1:0] CT_VIDEO_LA_ASF    = 6'd25;
  localparam logic [CT_W-1:0] CT_AUDIO_MPEGURL   = 6'd26;
  localparam logic [CT_W-1:0] CT_MSG_RFC822      = 6'd27;
  localparam logic [CT_W-1:0] CT_AUDIO_MID       = 6'd28;
  localparam logic [CT_W-1:0] CT_VIDEO_QUICKTIME = 6'd29;
  localparam logic [CT_W-1:0] CT_VIDEO_SGI_MOVIE = 6'd30;
  localparam logic [CT_W-1:0] CT_VIDEO_MPEG      = 6'd31;
  localparam logic [CT_W-1:0] CT_AUDIO_MPEG      = 6'd32;
  localparam logic [CT_W-1:0] CT_APP_ODA         = 6'd33;
  localparam logic [CT_W-1:0] CT_IMAGE_PBM       = 6'd34;
  localparam logic [CT_W-1:0] CT_APP_PDF         = 6'd35;
  localparam logic [CT_W-1:0] CT_IMAGE_PGM       = 6'd36;
  localparam logic [CT_W-1:0] CT_IMAGE_PNG       = 6'd37;
  localparam logic [CT_W-1:0] CT_IMAGE_PPM       = 6'd38;
  localparam logic [CT_W-1:0] CT_IMAGE_PNM       = 6'd39;
  localparam logic [CT_W-1:0] CT_AUDIO_REALAUDIO = 6'd40;
  localparam logic [CT_W-1:0] CT_IMAGE_RASTER    = 6'd41;
  localparam logic [CT_W-1:0] CT_IMAGE_RGB       = 6'd42;
  localparam logic [CT_W-1:0] CT_TEXT_RICHTEXT   = 6'd43;
  localparam logic [CT_W-1:0] CT_TEXT_SCRIPTLET  = 6'd44;
  localparam logic [CT_W-1:0] CT_APP_TAR         = 6'd45;
  localparam logic [CT_W-1:0] CT_IMAGE_TIFF      = 6'd46;
  localparam logic [CT_W-1:0] CT_TEXT_TSV        = 6'd47;
  localparam logic [CT_W-1:0] CT_TEXT_IULS       = 6'd48;
  localparam logic [CT_W-1:0] CT_TEXT_VCARD      = 6'd49;
  localparam logic [CT_W-1:0] CT_AUDIO_WAV       = 6'd50;
  localparam logic [CT_W-1:0] CT_IMAGE_XBM       = 6'd51;
  localparam logic [CT_W-1:0] CT_IMAGE_XPM       = 6'd52;
  localparam logic [CT_W-1:0] CT_IMAGE_XWD       = 6'd53;
  localparam logic [CT_W-1:0] CT_TEXT_XML        = 6'd54;
  localparam logic [CT_W-1:0] CT_APP_COMPRESS    = 6'd55;
  localparam logic [CT_W-1:0] CT_APP_ZIP         = 6'd56;

  // Extension held right-justified: first byte highest, zeros above
  typedef struct packed {
    logic [EXT_WORD_W-1:0] ext;
    logic [CT_W-1:0]       code;
  } ext_entry_t;

  // Every extension appears once, so at most one entry can hit
  localparam ext_entry_t EXT_TABLE [EXT_STORED] = '{
    '{"323", CT_TEXT_H323},        '{"AI", CT_APP_POSTSCRIPT},
    '{"AIF", CT_AUDIO_AIFF},       '{"AIFC", CT_AUDIO_AIFF},
    '{"AIFF", CT_AUDIO_AIFF},      '{"ASF", CT_VIDEO_ASF},
    '{"ASP", CT_TEXT_HTML},        '{"ASR", CT_VIDEO_ASF},
    '{"ASX", CT_VIDEO_ASF},        '{"AU", CT_AUDIO_BASIC},
    '{"AVI", CT_VIDEO_MSVIDEO},    '{"BAS", CT_TEXT_PLAIN},
    '{"BIN", CT_APP_OCTET},        '{"BMP", CT_IMAGE_BMP},
    '{"C", CT_TEXT_PLAIN},         '{"CPP", CT_TEXT_PLAIN},
    '{"CHM", CT_TEXT_HTML},        '{"CLA", CT_APP_OCTET},
    '{"CLASS", CT_APP_OCTET},      '{"COD", CT_IMAGE_CIS_COD},
    '{"CSS", CT_TEXT_CSS},         '{"DMS", CT_APP_OCTET},
    '{"EPS", CT_APP_POSTSCRIPT},   '{"ETX", CT_TEXT_SETEXT},
    '{"EXE", CT_APP_OCTET},        '{"FLR", CT_WORLD_VRML},
    '{"GIF", CT_IMAGE_GIF},        '{"GTAR", CT_APP_GTAR},
    '{"GZ", CT_APP_GZIP},          '{"GZIP", CT_APP_GZIP},
    '{"H", CT_TEXT_PLAIN},         '{"HPP", CT_TEXT_PLAIN},
    '{"HTM", CT_TEXT_HTML},        '{"HTML", CT_TEXT_HTML},
    '{"HTC", CT_TEXT_COMPONENT},   '{"HTT", CT_TEXT_WEBVIEW},
    '{"ICO", CT_IMAGE_ICON},       '{"IEF", CT_IMAGE_IEF},
    '{"JFIF", CT_IMAGE_PIPEG},     '{"JPE", CT_IMAGE_JPEG},
    '{"JPEG", CT_IMAGE_JPEG},      '{"JPG", CT_IMAGE_JPEG},
    '{"JS", CT_APP_JAVASCRIPT},    '{"JSP", CT_TEXT_HTML},
    '{"LHA", CT_APP_OCTET},        '{"LSF", CT_VIDEO_LA_ASF},
    '{"LSX", CT_VIDEO_LA_ASF},     '{"LZH", CT_APP_OCTET},
    '{"M3U", CT_AUDIO_MPEGURL},    '{"MHT", CT_MSG_RFC822},
    '{"MHTML", CT_MSG_RFC822},     '{"MID", CT_AUDIO_MID},
    '{"MOV", CT_VIDEO_QUICKTIME},  '{"MOVIE", CT_VIDEO_SGI_MOVIE},
    '{"MP2", CT_VIDEO_MPEG},       '{"MP3", CT_AUDIO_MPEG},
    '{"MPA", CT_VIDEO_MPEG},       '{"MPE", CT_VIDEO_MPEG},
    '{"MPEG", CT_VIDEO_MPEG},      '{"MPG", CT_VIDEO_MPEG},
    '{"MPV2", CT_VIDEO_MPEG},      '{"NWS", CT_MSG_RFC822},
    '{"ODA", CT_APP_ODA},          '{"PBM", CT_IMAGE_PBM},
    '{"PDF", CT_APP_PDF},          '{"PGM", CT_IMAGE_PGM},
    '{"PHP", CT_TEXT_HTML},        '{"PNG", CT_IMAGE_PNG},
    '{"PPM", CT_IMAGE_PPM},        '{"PNM", CT_IMAGE_PNM},
    '{"PS", CT_APP_POSTSCRIPT},    '{"QT", CT_VIDEO_QUICKTIME},
    '{"RA", CT_AUDIO_REALAUDIO},   '{"RAM", CT_AUDIO_REALAUDIO},
    '{"RAS", CT_IMAGE_RASTER},     '{"RGB", CT_IMAGE_RGB},
    '{"RMI", CT_AUDIO_MID},        '{"RTF", CT_TEXT_RICHTEXT},
    '{"RTX", CT_TEXT_RICHTEXT},    '{"SCT", CT_TEXT_SCRIPTLET},
    '{"SND", CT_AUDIO_BASIC},      '{"STM", CT_TEXT_HTML},
    '{"TAR", CT_APP_TAR},          '{"TEXT", CT_TEXT_PLAIN},
    '{"TIF", CT_IMAGE_TIFF},       '{"TIFF", CT_IMAGE_TIFF},
    '{"TSV", CT_TEXT_TSV},         '{"TXT", CT_TEXT_PLAIN},
    '{"ULS", CT_TEXT_IULS},        '{"VCF", CT_TEXT_VCARD},
    '{"VRML", CT_WORLD_VRML},      '{"WAV", CT_AUDIO_WAV},
    '{"WMV", CT_VIDEO_MSVIDEO},    '{"WRL", CT_WORLD_VRML},
    '{"WRZ", CT_WORLD_VRML},       '{"XAF", CT_WORLD_VRML},
    '{"XBM", CT_IMAGE_XBM},        '{"XOF", CT_WORLD_VRML},
    '{"XPM", CT_IMAGE_XPM},        '{"XWD", CT_IMAGE_XWD},
    '{"XML", CT_TEXT_XML},         '{"Z", CT_APP_COMPRESS},
    '{"ZIP", CT_APP_ZIP}
  };

endpackage

// File: rtl/content_type_by_extension_unit.sv
// Top level of the content type by extension unit: scanner state and handshake.
// Depends on ctbe_pkg and ctbe_lookup.
//
// Usage: stream a file name or URL in on the slave channel, one byte per word,
// with tlast on the final byte. For each name one word comes out on the master
// channel carrying the content-type code (0 for unknown). Bytes not marked
// last give no output word.
// Scanning stops at a NUL or '?', a '.' opens a new extension, '/' or '\'
// drops it; extension bytes are upper-cased and the first MAX_EXT_CHARS kept.
// The result word is registered: a final byte passes the input register, then
// scan update and table compare load the output register. Throughput: one
// byte per cycle while no final byte waits for the output register, set by the
// combinational scan update and comparator bank; names may follow back to back.
// Reset clears the scan state and both valid flags; the block is ready to
// take a byte in the first cycle after reset.
// Stall: a result waiting in the output register holds while m_axis_tready_i
// is low. Bytes that are not last keep flowing; a final byte waits in the
// input register until the output register frees, and input then backs up.
module content_type_by_extension_unit #(
  parameter int MAX_EXT_CHARS = ctbe_pkg::MAX_EXT_CHARS_DEF,
  parameter int TABLE_ENTRIES = ctbe_pkg::TABLE_ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] name_char
  input  logic       s_axis_tlast_i,   // last_char
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [5:0] content_type, [7:6] zero
);
  import ctbe_pkg::*;

  localparam int LEN_W = $clog2(MAX_EXT_CHARS + 1);

  // Input register
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_last_q;

  // Scan state
  logic [7:0]       ext_chars_q [MAX_EXT_CHARS];
  logic [7:0]       ext_chars_d [MAX_EXT_CHARS];
  logic [LEN_W-1:0] ext_len_q, ext_len_d;
  logic             ext_present_q, ext_present_d;
  logic             scan_stopped_q, scan_stopped_d;

  // Output register
  logic            out_valid_q;
  logic [CT_W-1:0] out_type_q;

  logic                  out_free;
  logic                  step_fire;
  logic                  in_fire;
  logic [7:0]            upper_char;
  logic [EXT_WORD_W-1:0] ext_word;
  logic                  ext_ok;
  logic [CT_W-1:0]       lookup_type;

  // A final byte needs room in the output register; other bytes always advance
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step_fire       = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || step_fire;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign upper_char = ((in_char_q >= CHAR_LOW_A) && (in_char_q <= CHAR_LOW_Z)) ?
                      (in_char_q - CASE_OFFSET) : in_char_q;

  // Scan update for the byte in the input register
  always_comb begin
    ext_chars_d    = ext_chars_q;
    ext_len_d      = ext_len_q;
    ext_present_d  = ext_present_q;
    scan_stopped_d = scan_stopped_q;
    if (!scan_stopped_q) begin
      case (in_char_q)
        CHAR_NUL, CHAR_QMARK: begin
          scan_stopped_d = 1'b1;
        end
        CHAR_DOT: begin
          ext_present_d = 1'b1;
          ext_len_d     = '0;
        end
        CHAR_SLASH, CHAR_BSLASH: begin
          ext_present_d = 1'b0;
          ext_len_d     = '0;
        end
        default: begin
          if (ext_present_q && (ext_len_q < LEN_W'(MAX_EXT_CHARS))) begin
            for (int j = 0; j < MAX_EXT_CHARS; j++) begin
              if (ext_len_q == LEN_W'(j)) begin
                ext_chars_d[j] = upper_char;
              end
            end
            ext_len_d = ext_len_q + LEN_W'(1);
          end
        end
      endcase
    end
  end

  // Pack the kept extension right-justified, as the table holds it.
  // Kept bytes are never NUL, so equal words mean equal lengths too.
  always_comb begin
    ext_word = '0;
    for (int k = 0; k < EXT_CMP - 1; k++) begin
      if (ext_len_d > LEN_W'(k)) begin
        ext_word = {ext_word[EXT_WORD_W-9:0], ext_chars_d[k]};
      end
    end
  end

  // Extensions of EXT_CMP bytes or more match nothing
  assign ext_ok = ext_present_d && (ext_len_d != '0) &&
                  ({{(32-LEN_W){1'b0}}, ext_len_d} < 32'(EXT_CMP));

  ctbe_lookup #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_lookup (
    .ext_word_i    (ext_word),
    .ext_ok_i      (ext_ok),
    .content_type_o(lookup_type)
  );

  // Input register: hold until the byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (step_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Scan state: advance on each consumed byte, clear after a final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_len_q      <= '0;
      ext_present_q  <= 1'b0;
      scan_stopped_q <= 1'b0;
    end else if (step_fire) begin
      if (in_last_q) begin
        ext_len_q      <= '0;
        ext_present_q  <= 1'b0;
        scan_stopped_q <= 1'b0;
      end else begin
        ext_len_q      <= ext_len_d;
        ext_present_q  <= ext_present_d;
        scan_stopped_q <= scan_stopped_d;
      end
    end
  end

  // Extension bytes are only read below the kept length, so they need no reset
  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      ext_chars_q <= ext_chars_d;
    end
  end

  // Output register: load on a final byte, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && in_last_q) begin
      out_type_q <= lookup_type;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_type_q};

endmodule

// File: rtl/ctbe_lookup.sv
// Parallel comparator bank over the constant extension table.
// Depends on ctbe_pkg for the table, its entry type and the code width.
module ctbe_lookup #(
  parameter int TABLE_ENTRIES = ctbe_pkg::TABLE_ENTRIES_DEF
) (
  input  logic [ctbe_pkg::EXT_WORD_W-1:0] ext_word_i,
  input  logic                            ext_ok_i,
  output logic [ctbe_pkg::CT_W-1:0]       content_type_o
);
  import ctbe_pkg::*;

  localparam int SEARCHED = (TABLE_ENTRIES < EXT_STORED) ? TABLE_ENTRIES : EXT_STORED;

  // Entries are unique, so OR the hit codes together
  always_comb begin
    content_type_o = CT_UNKNOWN;
    for (int i = 0; i < SEARCHED; i++) begin
      if (ext_ok_i && (ext_word_i == EXT_TABLE[i].ext)) begin
        content_type_o = content_type_o | EXT_TABLE[i].code;
      end
    end
  end

endmodule
